@@ rtl/core/vdle_pkg.sv @@
package vdle_pkg;

  // opcode in bits 15..13 of the first word
  typedef enum logic [2:0] {
    OP_LONG   = 3'd0,
    OP_HALT   = 3'd1,
    OP_SHORT  = 3'd2,
    OP_STAT   = 3'd3,
    OP_CENTER = 3'd4,
    OP_CALL   = 3'd5,
    OP_RET    = 3'd6,
    OP_JUMP   = 3'd7
  } op_e;

  typedef enum logic [2:0] {
    VAR_PLAIN   = 3'd0,
    VAR_TANK    = 3'd1,
    VAR_BIPLANE = 3'd2,
    VAR_TUBE    = 3'd3,
    VAR_NARROW  = 3'd4,
    VAR_SPACE   = 3'd5,
    VAR_HAVOC   = 3'd6
  } variant_e;

  typedef enum logic [1:0] {
    CFG_VARIANT   = 2'd0,
    CFG_SCALE_MUL = 2'd1,
    CFG_MIRROR_X  = 2'd2,
    CFG_MIRROR_Y  = 2'd3
  } cfg_reg_e;

  typedef enum logic [1:0] {
    FAULT_NONE  = 2'd0,
    FAULT_UNDER = 2'd1,
    FAULT_OVER  = 2'd2
  } fault_e;

  localparam int unsigned FracBitsDef   = 16;
  localparam int unsigned StackDepthDef = 8;

  localparam logic [15:0] LfsrTaps    = 16'hB400;
  localparam logic [15:0] LfsrReset   = 16'h0001;
  localparam logic [1:0]  ScaleMulRst = 2'd2;
  localparam logic [3:0]  ZMask       = 4'he;
  localparam logic [7:0]  LevelMax    = 8'hff;
  localparam logic [3:0]  ZUseStatus  = 4'd2;
  localparam int unsigned CenterSpaceX = 379;
  localparam int unsigned CenterSpaceY = 410;
  localparam int unsigned CenterStd    = 512;

  typedef struct packed {
    variant_e   variant;
    logic [1:0] scale_mul;
    logic       mirror_x;
    logic       mirror_y;
  } vdle_cfg_t;

  typedef struct packed {
    logic [15:0] pc;
    logic [31:0] beam_x;
    logic [31:0] beam_y;
    logic [19:0] scale;
    logic [7:0]  level;
    logic [3:0]  color;
    logic        sparkle;
    logic        run_mirror_x;
    logic [1:0]  bank;
    logic [15:0] lfsr;
  } vdle_arch_t;

  typedef struct packed {
    logic               draw_valid;
    logic signed [15:0] start_x;
    logic signed [15:0] start_y;
    logic signed [15:0] end_x;
    logic signed [15:0] end_y;
    logic [7:0]         beam_level;
    logic [3:0]         color_index;
    logic [15:0]        next_address;
    logic               run_done;
    fault_e             fault;
    logic [1:0]         bank_select;
  } vdle_result_t;

endpackage

@@ rtl/core/vdle_exec.sv @@
module vdle_exec import vdle_pkg::*; #(
  parameter int unsigned FRAC_BITS   = FracBitsDef,
  parameter int unsigned STACK_DEPTH = StackDepthDef,
  localparam int unsigned SpW        = $clog2(STACK_DEPTH)
) (
  input  logic           start_run_i,
  input  logic [15:0]    first_word_i,
  input  logic [15:0]    second_word_i,
  input  vdle_cfg_t      cfg_i,
  input  vdle_arch_t     arch_i,
  input  logic [SpW-1:0] sp_i,
  input  logic [15:0]    stack_rdata_i,
  output logic [SpW-1:0] stack_raddr_o,
  output logic           push_o,
  output logic [SpW-1:0] push_addr_o,
  output logic [15:0]    push_data_o,
  output vdle_arch_t     arch_o,
  output logic [SpW-1:0] sp_o,
  output vdle_result_t   res_o
);

  localparam logic [SpW-1:0] SpTop = SpW'(STACK_DEPTH - 1);

  vdle_arch_t         eff;
  logic [SpW-1:0]     sp_eff;
  op_e                op;
  logic [15:0]        pc_inc;
  logic [15:0]        jmp_addr;
  logic               narrow, space, tube, havoc;
  logic signed [12:0] dlt_x, dlt_y;
  logic [3:0]         z_raw;
  logic               draw_cmd;
  logic [15:0]        lfsr_nx;
  logic signed [33:0] prod_x, prod_y;
  logic [31:0]        nx, ny;
  logic [11:0]        z_mul;
  logic [7:0]         z_fin;
  logic [7:0]         lvl;
  logic [FRAC_BITS+7:0] sc_full;
  logic [FRAC_BITS+7:0] sc_sh;
  logic [31:0]        sc_prod;
  logic signed [31:0] px0, py0, px1, py1;

  always_comb begin
    eff    = arch_i;
    sp_eff = sp_i;
    if (start_run_i) begin
      eff.pc           = '0;
      eff.level        = '0;
      eff.scale        = '0;
      eff.beam_x       = '0;
      eff.beam_y       = '0;
      eff.run_mirror_x = 1'b0;
      sp_eff           = '0;
    end
  end

  assign op       = op_e'(first_word_i[15:13]);
  assign pc_inc   = eff.pc + ((op == OP_LONG) ? 16'd4 : 16'd2);
  assign jmp_addr = {2'b00, first_word_i[12:0], 1'b0};
  assign narrow   = (cfg_i.variant == VAR_NARROW);
  assign space    = (cfg_i.variant == VAR_SPACE);
  assign tube     = (cfg_i.variant == VAR_TUBE);
  assign havoc    = (cfg_i.variant == VAR_HAVOC);
  assign lfsr_nx  = {1'b0, eff.lfsr[15:1]} ^ (eff.lfsr[0] ? LfsrTaps : 16'h0000);

  // vector deltas and raw intensity
  always_comb begin
    dlt_x    = '0;
    dlt_y    = '0;
    z_raw    = '0;
    draw_cmd = 1'b0;
    if (op == OP_LONG) begin
      draw_cmd = 1'b1;
      z_raw    = second_word_i[15:12] & ZMask;
      if (narrow) begin
        dlt_x = {second_word_i[11], second_word_i[11:0]};
        dlt_y = {first_word_i[11], first_word_i[11:0]};
      end else begin
        dlt_x = second_word_i[12:0];
        dlt_y = first_word_i[12:0];
      end
    end else if (op == OP_SHORT) begin
      draw_cmd = 1'b1;
      z_raw    = first_word_i[7:4] & ZMask;
      dlt_x    = {{7{first_word_i[4]}}, first_word_i[4:0], 1'b0};
      dlt_y    = {{7{first_word_i[12]}}, first_word_i[12:8], 1'b0};
    end
  end

  assign prod_x = dlt_x * $signed({1'b0, eff.scale});
  assign prod_y = dlt_y * $signed({1'b0, eff.scale});

  assign nx = (eff.run_mirror_x ^ cfg_i.mirror_x) ? (eff.beam_x - prod_x[31:0])
                                                  : (eff.beam_x + prod_x[31:0]);
  assign ny = cfg_i.mirror_y ? (eff.beam_y + prod_y[31:0]) : (eff.beam_y - prod_y[31:0]);

  // intensity
  assign z_mul = {8'h00, z_raw} * {4'h0, eff.level};
  always_comb begin
    if (space) begin
      z_fin = z_mul[11] ? LevelMax : z_mul[10:3];
    end else if (z_raw == ZUseStatus) begin
      z_fin = eff.level;
    end else begin
      z_fin = {4'h0, z_raw};
    end
    if (space) begin
      lvl = z_fin;
    end else if (tube || narrow) begin
      lvl = {z_fin[3:0], 4'h0};
    end else begin
      lvl = {z_fin[3:1], 5'b00000};
    end
  end

  // scale word
  assign sc_full = {~first_word_i[7:0], {FRAC_BITS{1'b0}}};
  assign sc_sh   = sc_full >> ({1'b0, first_word_i[10:8]} + 4'd8);
  assign sc_prod = 32'(sc_sh) * {30'd0, cfg_i.scale_mul};

  assign px0 = $signed(eff.beam_x) >>> FRAC_BITS;
  assign py0 = $signed(eff.beam_y) >>> FRAC_BITS;
  assign px1 = $signed(nx) >>> FRAC_BITS;
  assign py1 = $signed(ny) >>> FRAC_BITS;

  assign stack_raddr_o = sp_eff - SpW'(1);
  assign push_addr_o   = sp_eff;
  assign push_data_o   = pc_inc;

  always_comb begin
    arch_o    = eff;
    arch_o.pc = pc_inc;
    sp_o      = sp_eff;
    push_o    = 1'b0;
    res_o     = '0;

    case (op)
      OP_LONG, OP_SHORT: begin
        if (op == OP_LONG && eff.sparkle) begin
          arch_o.lfsr  = lfsr_nx;
          arch_o.color = lfsr_nx[3:0];
        end
        arch_o.beam_x = nx;
        arch_o.beam_y = ny;
      end
      OP_HALT: begin
        res_o.run_done = 1'b1;
      end
      OP_STAT: begin
        if (first_word_i[12]) begin
          arch_o.scale = sc_prod[19:0];
        end else if (space) begin
          arch_o.color = {1'b0, first_word_i[10:8]};
          arch_o.level = first_word_i[7:0];
        end else begin
          arch_o.level = {4'h0, first_word_i[7:4]};
          arch_o.color = {1'b0, first_word_i[2:0]};
          if (tube) begin
            arch_o.sparkle = ~first_word_i[11];
            arch_o.color   = first_word_i[3:0];
          end
          if (havoc) begin
            arch_o.sparkle      = first_word_i[11];
            arch_o.run_mirror_x = first_word_i[10];
            arch_o.bank         = first_word_i[9:8];
          end
        end
      end
      OP_CENTER: begin
        if (space) begin
          arch_o.beam_x = 32'(CenterSpaceX) << FRAC_BITS;
          arch_o.beam_y = 32'(CenterSpaceY) << FRAC_BITS;
        end else begin
          arch_o.beam_x = 32'(CenterStd) << FRAC_BITS;
          arch_o.beam_y = 32'(CenterStd) << FRAC_BITS;
        end
      end
      OP_CALL: begin
        if (jmp_addr == '0) begin
          res_o.run_done = 1'b1;
        end else begin
          push_o = 1'b1;
          if (sp_eff == SpTop) begin
            res_o.run_done = 1'b1;
            res_o.fault    = FAULT_OVER;
            sp_o           = '0;
          end else begin
            sp_o      = sp_eff + SpW'(1);
            arch_o.pc = jmp_addr;
          end
        end
      end
      OP_RET: begin
        if (sp_eff == '0) begin
          res_o.run_done = 1'b1;
          res_o.fault    = FAULT_UNDER;
          sp_o           = SpTop;
        end else begin
          sp_o      = sp_eff - SpW'(1);
          arch_o.pc = stack_rdata_i;
        end
      end
      OP_JUMP: begin
        if (jmp_addr == '0) begin
          res_o.run_done = 1'b1;
        end else begin
          arch_o.pc = jmp_addr;
        end
      end
      default: begin
        res_o.run_done = 1'b1;
      end
    endcase

    if (draw_cmd && (z_fin != '0)) begin
      res_o.draw_valid  = 1'b1;
      res_o.start_x     = px0[15:0];
      res_o.start_y     = py0[15:0];
      res_o.end_x       = px1[15:0];
      res_o.end_y       = py1[15:0];
      res_o.beam_level  = lvl;
      res_o.color_index = arch_o.color;
    end
    res_o.next_address = arch_o.pc;
    res_o.bank_select  = arch_o.bank;
  end

endmodule

@@ rtl/core/vector_display_list_engine.sv @@
// vector display-list engine
//
// input channel (in_valid_i / in_ready_o) carries one instruction word per
// handshake: start_run_i, first_word_i and, for long vectors, second_word_i.
// output channel (out_valid_o / out_ready_i) returns one result word per
// instruction: the segment drawn (if any) with level and color index, the
// next fetch address, end-of-run flag, stack fault and vector bank.
// configuration registers are written through cfg_we_i / cfg_idx_i /
// cfg_data_i while the engine is idle; the user must keep to this, as the
// block does not enforce it.
//
// throughput: one instruction per cycle while out_ready_i is high; the
// bound is the execute stage, a decode, two 13x20 multiplies and the beam
// add between the input register and the result register.
// reset clears the beam, scale, level, color, program counter and stack
// pointer; the lfsr restarts at one. when the receiver stalls the result
// register holds, the input register fills, and then in_ready_o drops.
module vector_display_list_engine import vdle_pkg::*; #(
  parameter int unsigned FRAC_BITS   = FracBitsDef,
  parameter int unsigned STACK_DEPTH = StackDepthDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration write port
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [2:0]         cfg_data_i,
  // instruction words in
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               start_run_i,
  input  logic [15:0]        first_word_i,
  input  logic [15:0]        second_word_i,
  // result words out
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               draw_valid_o,
  output logic signed [15:0] start_x_o,
  output logic signed [15:0] start_y_o,
  output logic signed [15:0] end_x_o,
  output logic signed [15:0] end_y_o,
  output logic [7:0]         beam_level_o,
  output logic [3:0]         color_index_o,
  output logic [15:0]        next_address_o,
  output logic               run_done_o,
  output logic [1:0]         fault_o,
  output logic [1:0]         bank_select_o
);

  localparam int unsigned SpW = $clog2(STACK_DEPTH);

  // configuration registers
  logic [2:0] variant_q;
  logic [1:0] scale_mul_q;
  logic       mirror_x_q;
  logic       mirror_y_q;
  vdle_cfg_t  cfg;

  // input register
  logic        s1_valid_q;
  logic        s1_start_q;
  logic [15:0] s1_first_word_q;
  logic [15:0] s1_second_word_q;

  // architectural state
  vdle_arch_t     arch_q, arch_d;
  logic [SpW-1:0] sp_q, sp_d;
  logic [15:0]    stack_q [STACK_DEPTH];

  // stack access from the execute stage
  logic [SpW-1:0] stack_raddr;
  logic           push;
  logic [SpW-1:0] push_addr;
  logic [15:0]    push_data;

  // result register
  logic         out_valid_q;
  vdle_result_t res_d, res_q;

  logic adv;

  // the execute stage fires when an instruction waits and the result slot
  // is free or being emptied this cycle
  assign adv        = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || adv;

  // unused variant codes decode as plain
  assign cfg.variant   = (variant_q > 3'(VAR_HAVOC)) ? VAR_PLAIN : variant_e'(variant_q);
  assign cfg.scale_mul = scale_mul_q;
  assign cfg.mirror_x  = mirror_x_q;
  assign cfg.mirror_y  = mirror_y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      variant_q   <= 3'(VAR_PLAIN);
      scale_mul_q <= ScaleMulRst;
      mirror_x_q  <= 1'b0;
      mirror_y_q  <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        CFG_VARIANT:   variant_q   <= cfg_data_i;
        CFG_SCALE_MUL: scale_mul_q <= cfg_data_i[1:0];
        CFG_MIRROR_X:  mirror_x_q  <= cfg_data_i[0];
        CFG_MIRROR_Y:  mirror_y_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // input stage control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  // input stage payload
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_start_q       <= start_run_i;
      s1_first_word_q  <= first_word_i;
      s1_second_word_q <= second_word_i;
    end
  end

  vdle_exec #(
    .FRAC_BITS  (FRAC_BITS),
    .STACK_DEPTH(STACK_DEPTH)
  ) u_exec (
    .start_run_i  (s1_start_q),
    .first_word_i (s1_first_word_q),
    .second_word_i(s1_second_word_q),
    .cfg_i        (cfg),
    .arch_i       (arch_q),
    .sp_i         (sp_q),
    .stack_rdata_i(stack_q[stack_raddr]),
    .stack_raddr_o(stack_raddr),
    .push_o       (push),
    .push_addr_o  (push_addr),
    .push_data_o  (push_data),
    .arch_o       (arch_d),
    .sp_o         (sp_d),
    .res_o        (res_d)
  );

  // state commits together with the result word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      arch_q      <= '{lfsr: LfsrReset, default: '0};
      sp_q        <= '0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      arch_q      <= arch_d;
      sp_q        <= sp_d;
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // return stack, entries hold nothing useful until pushed
  always_ff @(posedge clk_i) begin
    if (adv && push) begin
      stack_q[push_addr] <= push_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign draw_valid_o   = res_q.draw_valid;
  assign start_x_o      = res_q.start_x;
  assign start_y_o      = res_q.start_y;
  assign end_x_o        = res_q.end_x;
  assign end_y_o        = res_q.end_y;
  assign beam_level_o   = res_q.beam_level;
  assign color_index_o  = res_q.color_index;
  assign next_address_o = res_q.next_address;
  assign run_done_o     = res_q.run_done;
  assign fault_o        = res_q.fault;
  assign bank_select_o  = res_q.bank_select;

`ifndef SYNTHESIS
  a_exec_fills_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv |=> out_valid_q)
    else $error("executed instruction did not produce a result word");

  a_fault_ends_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && (res_d.fault != FAULT_NONE) |-> res_d.run_done)
    else $error("stack fault without end of run");

  a_blank_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !draw_valid_o |-> (beam_level_o == '0) && (color_index_o == '0))
    else $error("level or color set on a result with no segment");

  a_input_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !adv |=> s1_valid_q && $stable(s1_first_word_q))
    else $error("waiting instruction lost from the input register");
`endif

endmodule

@@ tb/vector_display_list_engine_tb.sv @@
module vector_display_list_engine_tb;
  import vdle_pkg::*;

  localparam int unsigned CycleLimit = 400000;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [1:0]         cfg_idx_i;
  logic [2:0]         cfg_data_i;
  logic               in_valid_i;
  logic               in_ready_o;
  logic               start_run_i;
  logic [15:0]        first_word_i;
  logic [15:0]        second_word_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic               draw_valid_o;
  logic signed [15:0] start_x_o;
  logic signed [15:0] start_y_o;
  logic signed [15:0] end_x_o;
  logic signed [15:0] end_y_o;
  logic [7:0]         beam_level_o;
  logic [3:0]         color_index_o;
  logic [15:0]        next_address_o;
  logic               run_done_o;
  logic [1:0]         fault_o;
  logic [1:0]         bank_select_o;

  vector_display_list_engine DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .start_run_i   (start_run_i),
    .first_word_i  (first_word_i),
    .second_word_i (second_word_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .draw_valid_o  (draw_valid_o),
    .start_x_o     (start_x_o),
    .start_y_o     (start_y_o),
    .end_x_o       (end_x_o),
    .end_y_o       (end_y_o),
    .beam_level_o  (beam_level_o),
    .color_index_o (color_index_o),
    .next_address_o(next_address_o),
    .run_done_o    (run_done_o),
    .fault_o       (fault_o),
    .bank_select_o (bank_select_o)
  );

  // engine state as the testbench sees it
  variant_e    cfg_variant;
  logic [1:0]  cfg_mul;
  logic        cfg_mx;
  logic        cfg_my;
  logic [15:0] pc;
  logic [15:0] ret_stk [StackDepthDef];
  bit          ret_written [StackDepthDef];
  int unsigned sp;
  logic [31:0] beam_x;
  logic [31:0] beam_y;
  logic [19:0] vscale;
  logic [7:0]  status_level;
  logic [3:0]  color;
  logic        sparkle;
  logic        run_mirror;
  logic [1:0]  bank;
  logic [15:0] lfsr;

  vdle_result_t predicted_words [$];
  vdle_result_t oldest_word;
  int unsigned  error_count;
  int unsigned  cycle_count;
  int unsigned  tx_gap_pct;
  int unsigned  rx_stall_pct;
  int unsigned  rx_hold;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  // watchdog on the whole run
  initial begin
    while (cycle_count < CycleLimit) @(posedge clk_i);
    $display("Some tests failed");
    $finish;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %h expected %h (cycle %0d)", what, got, want, cycle_count);
    error_count++;
  endtask

  function automatic int unsigned pick_gap(input int unsigned pct);
    if ($urandom_range(99) >= pct) return 0;
    if ($urandom_range(9) == 0) return $urandom_range(12, 40);
    return $urandom_range(1, 3);
  endfunction

  function automatic logic [15:0] lfsr_step(input logic [15:0] v);
    logic [15:0] n;
    n = v >> 1;
    if (v[0]) n = n ^ LfsrTaps;
    return n;
  endfunction

  // beam position in fixed point to a 16 bit pixel coordinate
  function automatic logic [15:0] to_pixel(input logic [31:0] v);
    logic [31:0] t;
    t = $signed(v) >>> FracBitsDef;
    return t[15:0];
  endfunction

  // executes one instruction on the local state and gives the result word
  task automatic execute_word(input logic start, input logic [15:0] w1,
                              input logic [15:0] w2, output vdle_result_t r);
    op_e         op;
    logic [31:0] x, y, z, dx, dy, nx, ny;
    logic [63:0] s;
    logic [15:0] tgt;
    logic [7:0]  lvl_out;
    logic        draw;
    logic        space, tube, narrow;
    r = '0;
    x = '0;
    y = '0;
    z = '0;
    draw = 1'b0;
    space = (cfg_variant == VAR_SPACE);
    tube = (cfg_variant == VAR_TUBE);
    narrow = (cfg_variant == VAR_NARROW);
    if (start) begin
      pc = '0;
      sp = 0;
      status_level = '0;
      vscale = '0;
      beam_x = '0;
      beam_y = '0;
      run_mirror = 1'b0;
    end
    op = op_e'(w1[15:13]);
    pc = pc + ((op == OP_LONG) ? 16'd4 : 16'd2);
    tgt = {2'b00, w1[12:0], 1'b0};
    case (op)
      OP_LONG: begin
        if (narrow) begin
          x = {{20{w2[11]}}, w2[11:0]};
          y = {{20{w1[11]}}, w1[11:0]};
        end else begin
          x = {{19{w2[12]}}, w2[12:0]};
          y = {{19{w1[12]}}, w1[12:0]};
        end
        z = {28'd0, w2[15:13], 1'b0};
        if (sparkle) begin
          lfsr = lfsr_step(lfsr);
          color = lfsr[3:0];
        end
        draw = 1'b1;
      end
      OP_SHORT: begin
        x = {{27{w1[4]}}, w1[4:0]} << 1;
        y = {{27{w1[12]}}, w1[12:8]} << 1;
        z = {28'd0, w1[7:5], 1'b0};
        draw = 1'b1;
      end
      OP_STAT: begin
        if (w1[12]) begin
          s = {56'd0, ~w1[7:0]} << FracBitsDef;
          s = s >> (w1[10:8] + 8);
          s = s * cfg_mul;
          vscale = s[19:0];
        end else if (space) begin
          color = {1'b0, w1[10:8]};
          status_level = w1[7:0];
        end else begin
          status_level = {4'd0, w1[7:4]};
          color = {1'b0, w1[2:0]};
          if (tube) begin
            sparkle = ~w1[11];
            color = w1[3:0];
          end
          if (cfg_variant == VAR_HAVOC) begin
            sparkle = w1[11];
            run_mirror = w1[10];
            bank = w1[9:8];
          end
        end
      end
      OP_CENTER: begin
        if (space) begin
          beam_x = 32'(CenterSpaceX) << FracBitsDef;
          beam_y = 32'(CenterSpaceY) << FracBitsDef;
        end else begin
          beam_x = 32'(CenterStd) << FracBitsDef;
          beam_y = 32'(CenterStd) << FracBitsDef;
        end
      end
      OP_CALL: begin
        if (tgt == 16'd0) begin
          r.run_done = 1'b1;
        end else begin
          ret_stk[sp] = pc;
          ret_written[sp] = 1'b1;
          if (sp >= StackDepthDef - 1) begin
            r.run_done = 1'b1;
            r.fault = FAULT_OVER;
            sp = 0;
          end else begin
            sp++;
            pc = tgt;
          end
        end
      end
      OP_RET: begin
        if (sp == 0) begin
          r.run_done = 1'b1;
          r.fault = FAULT_UNDER;
          sp = StackDepthDef - 1;
        end else begin
          sp--;
          pc = ret_stk[sp];
        end
      end
      OP_JUMP: begin
        if (tgt == 16'd0) r.run_done = 1'b1;
        else pc = tgt;
      end
      OP_HALT: begin
        r.run_done = 1'b1;
      end
      default: begin
        r.run_done = 1'b1;
      end
    endcase
    if (draw) begin
      dx = x * {12'd0, vscale};
      dy = y * {12'd0, vscale};
      if (run_mirror) dx = 32'd0 - dx;
      if (cfg_my) dy = 32'd0 - dy;
      if (cfg_mx) dx = 32'd0 - dx;
      nx = beam_x + dx;
      ny = beam_y - dy;
      // space scales the level by the status setting, others substitute it for z of two
      if (space) begin
        z = (z * status_level) / 8;
        if (z > LevelMax) z = LevelMax;
      end else if (z == ZUseStatus) begin
        z = {24'd0, status_level};
      end
      if (z != 0) begin
        if (space) lvl_out = z[7:0];
        else if (tube || narrow) lvl_out = {z[3:0], 4'd0};
        else lvl_out = {z[3:1], 5'd0};
        r.draw_valid = 1'b1;
        r.start_x = to_pixel(beam_x);
        r.start_y = to_pixel(beam_y);
        r.end_x = to_pixel(nx);
        r.end_y = to_pixel(ny);
        r.beam_level = lvl_out;
        r.color_index = color;
      end
      beam_x = nx;
      beam_y = ny;
    end
    r.next_address = pc;
    r.bank_select = bank;
  endtask

  // sends one instruction word and predicts its result on acceptance
  task automatic send_word(input logic start, input logic [15:0] w1, input logic [15:0] w2);
    int unsigned  gap;
    int unsigned  eff_sp;
    vdle_result_t r;
    // never pop a stack entry that was never pushed
    eff_sp = start ? 0 : sp;
    if (op_e'(w1[15:13]) == OP_RET && eff_sp != 0 && !ret_written[eff_sp - 1]) begin
      w1[15:13] = OP_STAT;
      w1[12] = 1'b0;
    end
    gap = pick_gap(tx_gap_pct);
    @(negedge clk_i);
    if (gap != 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    start_run_i = start;
    first_word_i = w1;
    second_word_i = w2;
    do @(posedge clk_i); while (!in_ready_o);
    execute_word(start, w1, w2, r);
    predicted_words.push_back(r);
  endtask

  // sender holds off until every predicted word has come back
  task automatic wait_all_results();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (predicted_words.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [2:0] value);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_data_i = value;
    @(posedge clk_i);
    case (idx)
      CFG_VARIANT:   cfg_variant = variant_e'(value);
      CFG_SCALE_MUL: cfg_mul = value[1:0];
      CFG_MIRROR_X:  cfg_mx = value[0];
      CFG_MIRROR_Y:  cfg_my = value[0];
      default: ;
    endcase
  endtask

  task automatic set_config(input variant_e v, input logic [1:0] mul, input logic mx,
                            input logic my);
    wait_all_results();
    write_reg(CFG_VARIANT, v);
    write_reg(CFG_SCALE_MUL, {1'b0, mul});
    write_reg(CFG_MIRROR_X, {2'b0, mx});
    write_reg(CFG_MIRROR_Y, {2'b0, my});
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  // every opcode under the reset configuration, extremes of the deltas
  task automatic test_directed_ops();
    tx_gap_pct = 0;
    rx_stall_pct = 0;
    send_word(1'b1, {OP_STAT, 13'h1000}, 16'h0000);
    send_word(1'b0, {OP_STAT, 13'h00f7}, 16'hffff);
    send_word(1'b0, {OP_CENTER, 13'h0000}, 16'h0000);
    send_word(1'b0, 16'h0fff, 16'hefff);
    // most negative deltas, level taken from status
    send_word(1'b0, 16'h1000, 16'h3000);
    // zero intensity draws nothing
    send_word(1'b0, 16'h0123, 16'h0456);
    send_word(1'b0, {OP_SHORT, 5'h10, 3'b111, 5'h0f}, 16'h0000);
    send_word(1'b0, {OP_HALT, 13'h1fff}, 16'hffff);
    send_word(1'b0, {OP_JUMP, 13'h0000}, 16'h0000);
    send_word(1'b0, {OP_CALL, 13'h0000}, 16'h0000);
    send_word(1'b0, {OP_CALL, 13'h1fff}, 16'h0000);
    send_word(1'b0, {OP_JUMP, 13'h0abc}, 16'h0000);
    send_word(1'b0, {OP_RET, 13'h0000}, 16'h0000);
    // return on an empty stack
    send_word(1'b0, {OP_RET, 13'h1fff}, 16'h0000);
    // engine keeps going after the end of a run
    send_word(1'b0, {OP_SHORT, 5'h0f, 3'b001, 5'h10}, 16'h0000);
  endtask

  // nested calls until the stack overflows, then underflow and a pop
  task automatic test_stack_overflow();
    tx_gap_pct = 30;
    rx_stall_pct = 30;
    for (int i = 0; i < StackDepthDef; i++) begin
      send_word(i == 0, {OP_CALL, 13'(16 + 3 * i)}, 16'(i));
    end
    send_word(1'b0, {OP_RET, 13'h0000}, 16'h0000);
    send_word(1'b0, {OP_RET, 13'h0000}, 16'h0000);
  endtask

  // sparkle, space level clamp, havoc status bits and the narrow delta width
  task automatic test_variant_features();
    set_config(VAR_TUBE, 2'd1, 1'b0, 1'b0);
    send_word(1'b1, {OP_STAT, 13'h00f5}, 16'h0000);
    send_word(1'b0, 16'h0040, 16'he020);
    set_config(VAR_SPACE, 2'd3, 1'b1, 1'b1);
    send_word(1'b1, {OP_STAT, 13'h07ff}, 16'h0000);
    send_word(1'b0, 16'h0010, 16'he010);
    set_config(VAR_HAVOC, 2'd1, 1'b0, 1'b1);
    send_word(1'b1, {OP_STAT, 13'h0fa3}, 16'h0000);
    send_word(1'b0, 16'h0020, 16'hc030);
    set_config(VAR_NARROW, 2'd2, 1'b1, 1'b0);
    send_word(1'b1, {OP_STAT, 13'h1080}, 16'h0000);
    send_word(1'b0, 16'h0800, 16'h6800);
  endtask

  task automatic random_body_word(output logic [15:0] w1, output logic [15:0] w2);
    int unsigned pick;
    pick = $urandom_range(99);
    w1 = 16'($urandom);
    w2 = 16'($urandom);
    if (pick < 30) begin
      w1[15:13] = OP_LONG;
    end else if (pick < 55) begin
      w1[15:13] = OP_SHORT;
    end else if (pick < 65) begin
      w1[15:13] = OP_STAT;
    end else if (pick < 70) begin
      w1[15:13] = OP_CENTER;
    end else if (pick < 80) begin
      w1[15:13] = OP_CALL;
      if ($urandom_range(9) == 0) w1[12:0] = '0;
    end else if (pick < 90) begin
      w1[15:13] = OP_RET;
    end else if (pick < 96) begin
      w1[15:13] = OP_JUMP;
      if ($urandom_range(9) == 0) w1[12:0] = '0;
    end else begin
      w1[15:13] = OP_HALT;
    end
  endtask

  // display lists with random content over many configurations, some noise
  task automatic test_random_lists();
    int unsigned sent;
    int unsigned body;
    bit          paused;
    logic [15:0] w1, w2;
    paused = 1'b0;
    for (int phase = 0; phase < 14; phase++) begin
      if (phase < 7) begin
        set_config(variant_e'(phase), 2'(phase % 3 + 1), phase[0], phase[1]);
      end else begin
        set_config(variant_e'(phase % 7), 2'($urandom_range(1, 3)), 1'($urandom),
                   1'($urandom));
      end
      tx_gap_pct = (phase % 4 == 3) ? 0 : $urandom_range(10, 40);
      rx_stall_pct = (phase % 4 == 3) ? 0 : $urandom_range(10, 40);
      sent = 0;
      while (sent < 36) begin
        if ($urandom_range(9) == 0) begin
          send_word(1'($urandom), 16'($urandom), 16'($urandom));
          sent++;
        end else begin
          w1 = 16'($urandom);
          w1[15:12] = {OP_STAT, 1'b1};
          send_word(1'b1, w1, 16'($urandom));
          w1 = 16'($urandom);
          w1[15:12] = {OP_STAT, 1'b0};
          send_word(1'b0, w1, 16'($urandom));
          send_word(1'b0, {OP_CENTER, 13'($urandom)}, 16'($urandom));
          body = $urandom_range(3, 12);
          repeat (body) begin
            random_body_word(w1, w2);
            send_word(1'b0, w1, w2);
          end
          sent += body + 3;
        end
        // sender stops until the engine has drained
        if (phase == 5 && sent >= 18 && !paused) begin
          wait_all_results();
          paused = 1'b1;
        end
      end
    end
  endtask

  // receiver: random stalls, mostly short
  initial begin
    out_ready_i = 1'b0;
    rx_hold = 0;
    forever begin
      @(negedge clk_i);
      if (rx_hold != 0) begin
        rx_hold--;
        out_ready_i = 1'b0;
      end else begin
        rx_hold = pick_gap(rx_stall_pct);
        out_ready_i = (rx_hold == 0);
      end
    end
  end

  // compare each result word with the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (predicted_words.size() == 0) begin
        report_mismatch("word with no prediction", next_address_o, 32'd0);
      end else begin
        oldest_word = predicted_words.pop_front();
        if (draw_valid_o !== oldest_word.draw_valid)
          report_mismatch("draw_valid", draw_valid_o, oldest_word.draw_valid);
        if (start_x_o !== oldest_word.start_x)
          report_mismatch("start_x", start_x_o, oldest_word.start_x);
        if (start_y_o !== oldest_word.start_y)
          report_mismatch("start_y", start_y_o, oldest_word.start_y);
        if (end_x_o !== oldest_word.end_x)
          report_mismatch("end_x", end_x_o, oldest_word.end_x);
        if (end_y_o !== oldest_word.end_y)
          report_mismatch("end_y", end_y_o, oldest_word.end_y);
        if (beam_level_o !== oldest_word.beam_level)
          report_mismatch("beam_level", beam_level_o, oldest_word.beam_level);
        if (color_index_o !== oldest_word.color_index)
          report_mismatch("color_index", color_index_o, oldest_word.color_index);
        if (next_address_o !== oldest_word.next_address)
          report_mismatch("next_address", next_address_o, oldest_word.next_address);
        if (run_done_o !== oldest_word.run_done)
          report_mismatch("run_done", run_done_o, oldest_word.run_done);
        if (fault_o !== oldest_word.fault)
          report_mismatch("fault", fault_o, oldest_word.fault);
        if (bank_select_o !== oldest_word.bank_select)
          report_mismatch("bank_select", bank_select_o, oldest_word.bank_select);
      end
    end
  end

  initial begin
    int unsigned drain;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CFG_VARIANT;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    start_run_i = 1'b0;
    first_word_i = '0;
    second_word_i = '0;
    tx_gap_pct = 0;
    rx_stall_pct = 0;
    error_count = 0;
    // state after reset
    cfg_variant = VAR_PLAIN;
    cfg_mul = ScaleMulRst;
    cfg_mx = 1'b0;
    cfg_my = 1'b0;
    pc = '0;
    sp = 0;
    beam_x = '0;
    beam_y = '0;
    vscale = '0;
    status_level = '0;
    color = '0;
    sparkle = 1'b0;
    run_mirror = 1'b0;
    bank = '0;
    lfsr = LfsrReset;
    for (int i = 0; i < StackDepthDef; i++) begin
      ret_stk[i] = '0;
      ret_written[i] = 1'b0;
    end
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed_ops();
    test_stack_overflow();
    test_variant_features();
    test_random_lists();

    @(negedge clk_i);
    in_valid_i = 1'b0;
    drain = 0;
    while (predicted_words.size() != 0 && drain < 4000) begin
      @(posedge clk_i);
      drain++;
    end
    repeat (4) @(posedge clk_i);
    if (predicted_words.size() != 0)
      report_mismatch("words never returned", predicted_words.size(), 32'd0);
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
